@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the nearest-point RTL.
// Define ASSERT_OFF to compile all checks away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define PSND_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("%m: check failed");
`define PSND_ASSERT_NORST(label, clk, prop) \
	label: assert property (@(posedge clk) prop) else $error("%m: check failed");
`else
`define PSND_ASSERT(label, clk, rst_n, prop)
`define PSND_ASSERT_NORST(label, clk, prop)
`endif
`endif

@@ rtl/core/psnd_pkg.sv @@
// Shared constants and types for the nearest-point-on-segment block.
// No dependencies.
package psnd_pkg;
	localparam int CoordWidth = 16;
	localparam int ThrWidth = 16;
	localparam logic [15:0] ThrReset = 16'd64;
	localparam int IdxWidth = 3;

	localparam logic [IdxWidth-1:0] REG_SEG_START_X = 3'd0;
	localparam logic [IdxWidth-1:0] REG_SEG_START_Y = 3'd1;
	localparam logic [IdxWidth-1:0] REG_SEG_END_X = 3'd2;
	localparam logic [IdxWidth-1:0] REG_SEG_END_Y = 3'd3;
	localparam logic [IdxWidth-1:0] REG_HIT_THRESHOLD = 3'd4;

	// which point the projection lands on
	typedef enum logic [1:0] {
		SEL_START,
		SEL_END,
		SEL_MID
	} sel_t;
endpackage

@@ rtl/core/psnd_div_cell.sv @@
// One restoring-division cell: decides one quotient bit for the x and y lanes.
// Depends on assert_macros.svh.
`include "assert_macros.svh"
module psnd_div_cell #(
	parameter int RW = 52,
	parameter int DVW = 35,
	parameter int QW = 17,
	parameter int SHIFT = 0,
	parameter int SDW = 34
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic [RW-1:0]  in_rem_x,
	input  logic [RW-1:0]  in_rem_y,
	input  logic [DVW-1:0] in_dv,
	input  logic [QW-1:0]  in_quo_x,
	input  logic [QW-1:0]  in_quo_y,
	input  logic [SDW-1:0] in_side,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [RW-1:0]  out_rem_x,
	output logic [RW-1:0]  out_rem_y,
	output logic [DVW-1:0] out_dv,
	output logic [QW-1:0]  out_quo_x,
	output logic [QW-1:0]  out_quo_y,
	output logic [SDW-1:0] out_side
);
	logic [RW-1:0] dvs;
	logic          ge_x, ge_y;
	logic [QW-1:0] qbit;

	assign dvs = RW'(in_dv) << SHIFT;
	assign ge_x = in_rem_x >= dvs;
	assign ge_y = in_rem_y >= dvs;
	assign qbit = QW'(1) << SHIFT;
	assign in_ready = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (in_ready) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			out_rem_x <= ge_x ? in_rem_x - dvs : in_rem_x;
			out_rem_y <= ge_y ? in_rem_y - dvs : in_rem_y;
			out_quo_x <= ge_x ? (in_quo_x | qbit) : in_quo_x;
			out_quo_y <= ge_y ? (in_quo_y | qbit) : in_quo_y;
			out_dv <= in_dv;
			out_side <= in_side;
		end
	end

	`PSND_ASSERT(a_div_hold, clk, arst_n, out_valid && !out_ready |=> out_valid)
endmodule

@@ rtl/core/psnd_sqrt_cell.sv @@
// One digit-by-digit square-root cell: retires two radicand bits, one root bit.
// Depends on assert_macros.svh.
`include "assert_macros.svh"
module psnd_sqrt_cell #(
	parameter int QW = 17,
	parameter int SDW = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [2*QW-1:0]   in_v,
	input  logic [QW+2:0]     in_rem,
	input  logic [QW-1:0]     in_root,
	input  logic [SDW-1:0]    in_side,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [2*QW-1:0]   out_v,
	output logic [QW+2:0]     out_rem,
	output logic [QW-1:0]     out_root,
	output logic [SDW-1:0]    out_side
);
	localparam int RMW = QW + 3;
	logic [RMW-1:0] nr;
	logic [RMW-1:0] trial;
	logic           ge;

	assign nr = {in_rem[RMW-3:0], in_v[2*QW-1:2*QW-2]};
	assign trial = RMW'({in_root, 2'b01});
	assign ge = nr >= trial;
	assign in_ready = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (in_ready) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			out_v <= in_v << 2;
			out_rem <= ge ? nr - trial : nr;
			out_root <= {in_root[QW-2:0], ge};
			out_side <= in_side;
		end
	end

	// partial remainder never exceeds twice the partial root
	`PSND_ASSERT(a_sqrt_rem, clk, arst_n, out_valid |-> (out_rem <= RMW'({out_root, 1'b0})))
endmodule

@@ rtl/core/point_segment_nearest_distance.sv @@
// Top level: nearest point on a configured segment, distance and hit flag.
// Depends on psnd_pkg, psnd_div_cell, psnd_sqrt_cell, assert_macros.svh.
//
// channel  direction  handshake               payload
// s_       in         s_tvalid / s_tready     s_tdata: query_x, query_y
// m_       out        m_tvalid / m_tready     m_tdata: near_x, near_y, gap_length, hit
// cfg_     in         cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One query per cycle sustained while the output is not stalled. Stages: five front
// stages, one divider cell per quotient bit, three stages, one root cell
// per root bit, and the output register. Every stage has its own valid and passes
// on as soon as its successor frees, so bubbles close up under an output stall.
// Reset clears all valids; the segment resets to the origin, threshold to 64.
// cfg_ready is always high.
`include "assert_macros.svh"
module point_segment_nearest_distance #(
	parameter int COORD_WIDTH = psnd_pkg::CoordWidth
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// query_x, query_y
	input  logic [((2*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	// near_x, near_y, gap_length, hit
	output logic [((3*COORD_WIDTH+2+7)/8)*8-1:0] m_tdata,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [psnd_pkg::IdxWidth-1:0] cfg_index,
	input  logic [((COORD_WIDTH > psnd_pkg::ThrWidth) ? COORD_WIDTH
		: psnd_pkg::ThrWidth)-1:0] cfg_data
);
	localparam int W = COORD_WIDTH;
	localparam int DW = W + 1;
	localparam int PW = 2 * W + 2;
	localparam int DOTW = 2 * W + 3;
	localparam int RW = 3 * W + 4;
	localparam int QW = W + 1;
	localparam int DVW = PW + 1;
	localparam int SDW = 2 * W + 2;
	localparam int TW = psnd_pkg::ThrWidth;
	localparam int CMW = (QW > TW) ? QW : TW;
	localparam int TDO = ((3 * W + 2 + 7) / 8) * 8;

	logic [W-1:0]  sx_q, sy_q, ex_q, ey_q;
	logic [TW-1:0] thr_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sx_q <= '0;
			sy_q <= '0;
			ex_q <= '0;
			ey_q <= '0;
			thr_q <= psnd_pkg::ThrReset;
		end else if (cfg_valid) begin
			case (cfg_index)
				psnd_pkg::REG_SEG_START_X: sx_q <= cfg_data[W-1:0];
				psnd_pkg::REG_SEG_START_Y: sy_q <= cfg_data[W-1:0];
				psnd_pkg::REG_SEG_END_X: ex_q <= cfg_data[W-1:0];
				psnd_pkg::REG_SEG_END_Y: ey_q <= cfg_data[W-1:0];
				psnd_pkg::REG_HIT_THRESHOLD: thr_q <= cfg_data[TW-1:0];
				default: ;
			endcase
		end
	end

	logic signed [DW-1:0] dx, dy;
	logic [QW-1:0]        adx, ady;
	assign dx = $signed({ex_q[W-1], ex_q}) - $signed({sx_q[W-1], sx_q});
	assign dy = $signed({ey_q[W-1], ey_q}) - $signed({sy_q[W-1], sy_q});
	assign adx = dx[DW-1] ? QW'(-dx) : QW'(dx);
	assign ady = dy[DW-1] ? QW'(-dy) : QW'(dy);

	// stage handshakes
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	logic r_s1, r_s2, r_s3, r_s4, r_s5, r_s6, r_s7, r_s8, r_out;
	logic dv_v [0:QW];
	logic dv_r [0:QW];
	logic sq_v [0:QW];
	logic sq_r [0:QW];

	assign r_s1 = !v_s1 || r_s2;
	assign r_s2 = !v_s2 || r_s3;
	assign r_s3 = !v_s3 || r_s4;
	assign r_s4 = !v_s4 || r_s5;
	assign r_s5 = !v_s5 || dv_r[0];
	assign dv_v[0] = v_s5;
	assign r_s6 = !v_s6 || r_s7;
	assign dv_r[QW] = r_s6;
	assign r_s7 = !v_s7 || r_s8;
	assign r_s8 = !v_s8 || sq_r[0];
	assign sq_v[0] = v_s8;
	assign r_out = !m_tvalid || m_tready;
	assign sq_r[QW] = r_out;
	assign s_tready = r_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			m_tvalid <= 1'b0;
		end else begin
			if (r_s1) v_s1 <= s_tvalid;
			if (r_s2) v_s2 <= v_s1;
			if (r_s3) v_s3 <= v_s2;
			if (r_s4) v_s4 <= v_s3;
			if (r_s5) v_s5 <= v_s4;
			if (r_s6) v_s6 <= dv_v[QW];
			if (r_s7) v_s7 <= v_s6;
			if (r_s8) v_s8 <= v_s7;
			if (r_out) m_tvalid <= sq_v[QW];
		end
	end

	// s1: query offsets from the first endpoint
	logic [W-1:0]         qx_s1, qy_s1;
	logic signed [DW-1:0] px_s1, py_s1;
	always_ff @(posedge clk) begin
		if (r_s1 && s_tvalid) begin
			qx_s1 <= s_tdata[W-1:0];
			qy_s1 <= s_tdata[2*W-1:W];
			px_s1 <= $signed({s_tdata[W-1], s_tdata[W-1:0]})
				- $signed({sx_q[W-1], sx_q});
			py_s1 <= $signed({s_tdata[2*W-1], s_tdata[2*W-1:W]})
				- $signed({sy_q[W-1], sy_q});
		end
	end

	// s2: products for dot and squared length
	logic [W-1:0]         qx_s2, qy_s2;
	logic signed [PW-1:0] pdx_s2, pdy_s2, ddx_s2, ddy_s2;
	always_ff @(posedge clk) begin
		if (r_s2 && v_s1) begin
			qx_s2 <= qx_s1;
			qy_s2 <= qy_s1;
			pdx_s2 <= px_s1 * dx;
			pdy_s2 <= py_s1 * dy;
			ddx_s2 <= dx * dx;
			ddy_s2 <= dy * dy;
		end
	end

	// s3: dot, len2, region select
	logic signed [DOTW-1:0] dot;
	logic [PW-1:0]          len2;
	psnd_pkg::sel_t         sel;
	assign dot = DOTW'(pdx_s2) + DOTW'(pdy_s2);
	assign len2 = $unsigned(ddx_s2) + $unsigned(ddy_s2);
	always_comb begin
		if (len2 == '0 || dot[DOTW-1] || dot == '0) begin
			sel = psnd_pkg::SEL_START;
		end else if ($unsigned(dot) >= {1'b0, len2}) begin
			sel = psnd_pkg::SEL_END;
		end else begin
			sel = psnd_pkg::SEL_MID;
		end
	end

	logic [W-1:0]   qx_s3, qy_s3;
	logic [PW-1:0]  dotm_s3, len2_s3;
	psnd_pkg::sel_t sel_s3;
	always_ff @(posedge clk) begin
		if (r_s3 && v_s2) begin
			qx_s3 <= qx_s2;
			qy_s3 <= qy_s2;
			dotm_s3 <= dot[PW-1:0];
			len2_s3 <= len2;
			sel_s3 <= sel;
		end
	end

	// s4: |d| * dot in two partial products per axis
	logic [W-1:0]   qx_s4, qy_s4;
	logic [PW-1:0]  len2_s4, mxl_s4, mxh_s4, myl_s4, myh_s4;
	psnd_pkg::sel_t sel_s4;
	always_ff @(posedge clk) begin
		if (r_s4 && v_s3) begin
			qx_s4 <= qx_s3;
			qy_s4 <= qy_s3;
			len2_s4 <= len2_s3;
			sel_s4 <= sel_s3;
			mxl_s4 <= PW'(adx * dotm_s3[QW-1:0]);
			mxh_s4 <= PW'(adx * dotm_s3[PW-1:QW]);
			myl_s4 <= PW'(ady * dotm_s3[QW-1:0]);
			myh_s4 <= PW'(ady * dotm_s3[PW-1:QW]);
		end
	end

	// s5: rounding numerator 2*|d|*dot + len2 over 2*len2
	logic [RW-1:0] mx, my;
	assign mx = RW'(mxl_s4) + (RW'(mxh_s4) << QW);
	assign my = RW'(myl_s4) + (RW'(myh_s4) << QW);

	logic [RW-1:0]  remx [0:QW];
	logic [RW-1:0]  remy [0:QW];
	logic [DVW-1:0] dvv [0:QW];
	logic [QW-1:0]  quox [0:QW];
	logic [QW-1:0]  quoy [0:QW];
	logic [SDW-1:0] dside [0:QW];

	logic [RW-1:0]  numx_s5, numy_s5;
	logic [DVW-1:0] dv_s5;
	logic [SDW-1:0] side_s5;
	always_ff @(posedge clk) begin
		if (r_s5 && v_s4) begin
			numx_s5 <= (mx << 1) + RW'(len2_s4);
			numy_s5 <= (my << 1) + RW'(len2_s4);
			dv_s5 <= {len2_s4, 1'b0};
			side_s5 <= {sel_s4, qy_s4, qx_s4};
		end
	end

	assign remx[0] = numx_s5;
	assign remy[0] = numy_s5;
	assign dvv[0] = dv_s5;
	assign quox[0] = '0;
	assign quoy[0] = '0;
	assign dside[0] = side_s5;

	for (genvar i = 0; i < QW; i++) begin : g_div
		psnd_div_cell #(
			.RW(RW), .DVW(DVW), .QW(QW), .SHIFT(QW - 1 - i), .SDW(SDW)
		) u_cell (
			.clk(clk), .arst_n(arst_n),
			.in_valid(dv_v[i]), .in_ready(dv_r[i]),
			.in_rem_x(remx[i]), .in_rem_y(remy[i]), .in_dv(dvv[i]),
			.in_quo_x(quox[i]), .in_quo_y(quoy[i]), .in_side(dside[i]),
			.out_valid(dv_v[i+1]), .out_ready(dv_r[i+1]),
			.out_rem_x(remx[i+1]), .out_rem_y(remy[i+1]), .out_dv(dvv[i+1]),
			.out_quo_x(quox[i+1]), .out_quo_y(quoy[i+1]), .out_side(dside[i+1])
		);
	end

	// s6: nearest point and offset vector
	logic [W-1:0]   dqx, dqy;
	psnd_pkg::sel_t dsel;
	logic [W-1:0]   nx, ny;
	assign dqx = dside[QW][W-1:0];
	assign dqy = dside[QW][2*W-1:W];
	assign dsel = psnd_pkg::sel_t'(dside[QW][SDW-1:2*W]);

	always_comb begin
		case (dsel)
			psnd_pkg::SEL_END: begin
				nx = ex_q;
				ny = ey_q;
			end
			psnd_pkg::SEL_MID: begin
				nx = dx[DW-1] ? sx_q - W'(quox[QW]) : sx_q + W'(quox[QW]);
				ny = dy[DW-1] ? sy_q - W'(quoy[QW]) : sy_q + W'(quoy[QW]);
			end
			default: begin
				nx = sx_q;
				ny = sy_q;
			end
		endcase
	end

	logic [W-1:0]         nx_s6, ny_s6;
	logic signed [DW-1:0] vx_s6, vy_s6;
	always_ff @(posedge clk) begin
		if (r_s6 && dv_v[QW]) begin
			nx_s6 <= nx;
			ny_s6 <= ny;
			vx_s6 <= $signed({dqx[W-1], dqx}) - $signed({nx[W-1], nx});
			vy_s6 <= $signed({dqy[W-1], dqy}) - $signed({ny[W-1], ny});
		end
	end

	// s7: squares
	logic [W-1:0]         nx_s7, ny_s7;
	logic signed [PW-1:0] sqx_s7, sqy_s7;
	always_ff @(posedge clk) begin
		if (r_s7 && v_s6) begin
			nx_s7 <= nx_s6;
			ny_s7 <= ny_s6;
			sqx_s7 <= vx_s6 * vx_s6;
			sqy_s7 <= vy_s6 * vy_s6;
		end
	end

	// s8: squared distance
	logic [2*QW-1:0] sum_s8;
	logic [SDW-3:0]  nside_s8;
	always_ff @(posedge clk) begin
		if (r_s8 && v_s7) begin
			sum_s8 <= $unsigned(sqx_s7) + $unsigned(sqy_s7);
			nside_s8 <= {ny_s7, nx_s7};
		end
	end

	logic [2*QW-1:0] sv [0:QW];
	logic [QW+2:0]   srem [0:QW];
	logic [QW-1:0]   sroot [0:QW];
	logic [SDW-3:0]  sside [0:QW];
	assign sv[0] = sum_s8;
	assign srem[0] = '0;
	assign sroot[0] = '0;
	assign sside[0] = nside_s8;

	for (genvar k = 0; k < QW; k++) begin : g_sqrt
		psnd_sqrt_cell #(.QW(QW), .SDW(SDW - 2)) u_cell (
			.clk(clk), .arst_n(arst_n),
			.in_valid(sq_v[k]), .in_ready(sq_r[k]),
			.in_v(sv[k]), .in_rem(srem[k]), .in_root(sroot[k]), .in_side(sside[k]),
			.out_valid(sq_v[k+1]), .out_ready(sq_r[k+1]),
			.out_v(sv[k+1]), .out_rem(srem[k+1]), .out_root(sroot[k+1]),
			.out_side(sside[k+1])
		);
	end

	// output register
	logic hit;
	assign hit = CMW'(sroot[QW]) < CMW'(thr_q);
	always_ff @(posedge clk) begin
		if (r_out && sq_v[QW]) begin
			m_tdata <= TDO'({hit, sroot[QW], sside[QW]});
		end
	end

	`PSND_ASSERT(a_in_to_s1, clk, arst_n, s_tvalid && s_tready |=> v_s1)
	`PSND_ASSERT(a_out_source, clk, arst_n, $rose(m_tvalid) |-> $past(sq_v[QW]))
	`PSND_ASSERT(a_s5_from_s4, clk, arst_n, $rose(v_s5) |-> $past(v_s4))
endmodule

@@ verif/tb_top.sv @@
// Testbench for point_segment_nearest_distance: directed table, then random queries
// under three sender/receiver stall mixes. Depends on psnd_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb_top;
	// first member sits in the top bits, so hit leads and nx lands in [15:0]
	typedef struct packed {
		logic hit;
		logic [16:0] gap;
		logic signed [15:0] ny;
		logic signed [15:0] nx;
	} near_t;

	typedef struct {
		logic signed [15:0] sx, sy, ex, ey;
		logic [15:0] thr;
		logic signed [15:0] qx, qy;
		bit typed;
		near_t res;
	} row_t;

	localparam int WatchLimit = 5000;
	localparam int Settle = 50;

	logic clk = 0;
	logic arst_n = 0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [31:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 0;
	logic [55:0] m_tdata;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [psnd_pkg::IdxWidth-1:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;

	// configuration as the block should hold it
	logic signed [15:0] seg_sx = 0, seg_sy = 0, seg_ex = 0, seg_ey = 0;
	logic [15:0] thr = psnd_pkg::ThrReset;

	near_t pending[$];
	int errors = 0;
	int send_idle = 0, recv_idle = 0;
	int hold_left = 0;
	bit hold_req = 0;
	int quiet = 0;

	point_segment_nearest_distance dut (.*);

	always #1 clk = ~clk;

	function automatic longint offset_round(longint s, longint d, longint dot, longint len2);
		longint ad, q;
		ad = d < 0 ? -d : d;
		q = (2 * ad * dot + len2) / (2 * len2);
		return d < 0 ? s - q : s + q;
	endfunction

	function automatic near_t nearest_point(logic signed [15:0] qx_i, logic signed [15:0] qy_i);
		longint sx, sy, ex, ey, qx, qy, dx, dy, len2, dot, nx, ny, vx, vy, sq;
		longint unsigned r, t;
		near_t o;
		sx = seg_sx; sy = seg_sy; ex = seg_ex; ey = seg_ey; qx = qx_i; qy = qy_i;
		dx = ex - sx; dy = ey - sy;
		len2 = dx * dx + dy * dy;
		nx = sx; ny = sy;
		if (len2 != 0) begin
			dot = (qx - sx) * dx + (qy - sy) * dy;
			if (dot >= len2) begin
				nx = ex; ny = ey;
			end else if (dot > 0) begin
				nx = offset_round(sx, dx, dot, len2);
				ny = offset_round(sy, dy, dot, len2);
			end
		end
		vx = qx - nx; vy = qy - ny;
		sq = vx * vx + vy * vy;
		r = 0;
		for (int b = 18; b >= 0; b--) begin
			t = r | (64'd1 << b);
			if (t * t <= sq)
				r = t;
		end
		if (r > 131071)
			r = 131071;
		o.nx = nx[15:0];
		o.ny = ny[15:0];
		o.gap = r[16:0];
		o.hit = r < thr;
		return o;
	endfunction

	task automatic cfg_write(logic [psnd_pkg::IdxWidth-1:0] idx, logic [15:0] val);
		@(negedge clk);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			psnd_pkg::REG_SEG_START_X: seg_sx = val;
			psnd_pkg::REG_SEG_START_Y: seg_sy = val;
			psnd_pkg::REG_SEG_END_X: seg_ex = val;
			psnd_pkg::REG_SEG_END_Y: seg_ey = val;
			psnd_pkg::REG_HIT_THRESHOLD: thr = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 0;
	endtask

	task automatic set_segment(logic [15:0] sx, sy, ex, ey, t);
		cfg_write(psnd_pkg::REG_SEG_START_X, sx);
		cfg_write(psnd_pkg::REG_SEG_START_Y, sy);
		cfg_write(psnd_pkg::REG_SEG_END_X, ex);
		cfg_write(psnd_pkg::REG_SEG_END_Y, ey);
		cfg_write(psnd_pkg::REG_HIT_THRESHOLD, t);
	endtask

	// offer one request; typed result overrides the predictor when given
	task automatic send_query(logic [15:0] qx, logic [15:0] qy, bit typed, near_t res);
		@(negedge clk);
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 0;
			@(negedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= {qy, qx};
		do @(posedge clk); while (!s_tready);
		pending.push_back(typed ? res : nearest_point(qx, qy));
	endtask

	task automatic drain();
		@(negedge clk);
		s_tvalid <= 0;
		while (pending.size() != 0)
			@(posedge clk);
		repeat (Settle) @(posedge clk);
	endtask

	always @(negedge clk) begin
		if (hold_req && hold_left == 0) begin
			hold_left = 400;
			hold_req = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 0;
		end else
			m_tready <= $urandom_range(99) >= recv_idle;
	end

	always @(posedge clk) begin
		near_t got, want;
		if (m_tvalid && m_tready) begin
			got = m_tdata[49:0];
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result %h", got);
			end else begin
				want = pending.pop_front();
				if (got !== want) begin
					errors++;
					if (errors <= 10)
						$display("exp (%0d,%0d) gap=%0d hit=%0d, got (%0d,%0d) gap=%0d hit=%0d",
							want.nx, want.ny, want.gap, want.hit,
							got.nx, got.ny, got.gap, got.hit);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_valid || !arst_n)
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= WatchLimit) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	function automatic logic [15:0] rand_coord();
		case ($urandom_range(5))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'h0000;
			3: return 16'($urandom_range(511) - 256);
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] rand_thr();
		case ($urandom_range(4))
			0: return 16'h0000;
			1: return 16'hffff;
			2: return 16'($urandom_range(2047));
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] near_coord(logic signed [15:0] a, logic signed [15:0] b);
		int lo, hi;
		lo = a < b ? a : b;
		hi = a < b ? b : a;
		lo = lo - 300 < -32768 ? -32768 : lo - 300;
		hi = hi + 300 > 32767 ? 32767 : hi + 300;
		return 16'($urandom_range(hi - lo) + lo);
	endfunction

	row_t rows[$];

	function automatic row_t mk(int sx, sy, ex, ey, t, qx, qy, bit typed = 0,
		int nx = 0, ny = 0, gap = 0, bit h = 0);
		row_t r;
		r.sx = 16'(sx); r.sy = 16'(sy); r.ex = 16'(ex); r.ey = 16'(ey);
		r.thr = 16'(t); r.qx = 16'(qx); r.qy = 16'(qy);
		r.typed = typed;
		r.res = '{nx: 16'(nx), ny: 16'(ny), gap: 17'(gap), hit: h};
		return r;
	endfunction

	initial begin
		near_t none;
		none = '0;
		// first row runs on reset configuration
		rows.push_back(mk(0, 0, 0, 0, 64, 0, 0, 1, 0, 0, 0, 1));
		// degenerate segment
		rows.push_back(mk(100, -50, 100, -50, 64, 100, -2, 1, 100, -50, 48, 1));
		rows.push_back(mk(32767, 32767, 32767, 32767, 0, -32768, -32768, 1,
			32767, 32767, 92680, 0));
		// before start, past end, interior, exact endpoints
		rows.push_back(mk(0, 0, 160, 0, 64, -32, 16, 1, 0, 0, 35, 1));
		rows.push_back(mk(0, 0, 160, 0, 64, 320, 0, 1, 160, 0, 160, 0));
		rows.push_back(mk(0, 0, 160, 0, 64, 80, 30, 1, 80, 0, 30, 1));
		rows.push_back(mk(0, 0, 160, 0, 64, 0, 100, 1, 0, 0, 100, 0));
		rows.push_back(mk(0, 0, 160, 0, 64, 160, 5, 1, 160, 0, 5, 1));
		// half-LSB ties round away from the start, both directions
		rows.push_back(mk(0, 0, 2, 2, 64, 1, 0, 1, 1, 1, 1, 1));
		rows.push_back(mk(0, 0, -2, -2, 64, -1, 0, 1, -1, -1, 1, 1));
		// zero threshold never hits, max threshold
		rows.push_back(mk(0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0));
		rows.push_back(mk(0, 0, 0, 0, 65535, 0, 32767, 1, 0, 0, 32767, 1));
		rows.push_back(mk(-32768, -32768, -32768, -32768, 65535, 32767, 32767, 1,
			-32768, -32768, 92680, 0));
		// full-range and small segments, checked by the predictor
		rows.push_back(mk(-32768, -32768, 32767, 32767, 65535, 32767, -32768));
		rows.push_back(mk(-32768, -32768, 32767, 32767, 65535, -32768, 32767));
		rows.push_back(mk(-32768, -32768, 32767, 32767, 65535, 12345, -777));
		rows.push_back(mk(32767, -32768, -32768, 32767, 100, 0, 0));
		rows.push_back(mk(32767, -32768, -32768, 32767, 100, -1, -1));
		rows.push_back(mk(-32768, 32767, 32767, -32768, 1, 32767, 32767));
		rows.push_back(mk(5, 7, -3, 11, 9, 2, 9));
		rows.push_back(mk(5, 7, -3, 11, 9, -5, 15));

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		foreach (rows[i]) begin
			if (i != 0) begin
				drain();
				set_segment(rows[i].sx, rows[i].sy, rows[i].ex, rows[i].ey, rows[i].thr);
			end
			send_query(rows[i].qx, rows[i].qy, rows[i].typed, rows[i].typed ? rows[i].res : none);
		end

		for (int ph = 0; ph < 3; ph++) begin
			send_idle = ph == 0 ? 21 : ph == 1 ? 79 : 0;
			recv_idle = ph == 0 ? 79 : ph == 1 ? 21 : 0;
			for (int c = 0; c < 4; c++) begin
				drain();
				set_segment(rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_thr());
				if (ph == 2 && c == 1)
					hold_req = 1;
				for (int n = 0; n < 140; n++) begin
					if ($urandom_range(3) == 0)
						send_query(16'($urandom), 16'($urandom), 0, none);
					else
						send_query(near_coord(seg_sx, seg_ex), near_coord(seg_sy, seg_ey),
							0, none);
				end
			end
		end

		drain();
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/psnd_pkg.sv
rtl/core/psnd_div_cell.sv
rtl/core/psnd_sqrt_cell.sv
rtl/core/point_segment_nearest_distance.sv
verif/tb_top.sv
